### hdl/tfmc_pkg.sv
// Package for the ternary rule first-match classifier.
// Holds field widths, operation codes, controller states and the
// command and status structs shared by the controller and the datapath.
package tfmc_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned PatW    = 16;
  localparam int unsigned LenW    = 4;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned ValW    = 2;
  localparam int unsigned OutW    = 2;
  localparam int unsigned MatchW  = 6;
  localparam int unsigned InConds = 4;
  localparam int unsigned CondW   = IdxW + ValW;

  localparam logic [MatchW-1:0] NoMatch = '1;

  typedef enum logic [OpW-1:0] {
    OpAdd      = 2'd0,
    OpClassify = 2'd1,
    OpClear    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDeliver
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic deliver;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/tfmc_ctrl.sv
// Controller of the ternary rule first-match classifier.
// Sequences accept, rule scan and result delivery; depends on tfmc_pkg.
module tfmc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [tfmc_pkg::OpW-1:0] operation_i,
  output logic                   in_stall_o,
  input  tfmc_pkg::dp_status_t   status_i,
  output tfmc_pkg::ctrl_cmd_t    cmd_o
);
  import tfmc_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (operation_i == OpClassify) begin
            state_d = StScan;
          end else begin
            state_d = StDeliver;
          end
        end
      end
      StScan: begin
        if (status_i.scan_done) begin
          state_d = StDeliver;
        end
      end
      StDeliver: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.load    = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.deliver = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
      end
      StDeliver: begin
        cmd_o.deliver = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### hdl/tfmc_dp.sv
// Datapath of the ternary rule first-match classifier.
// Holds the rule memory, the rule count, the scan pipeline, the result
// holding registers and the output register; depends on tfmc_pkg.
module tfmc_dp #(
  parameter int unsigned MAX_RULES         = 32,
  parameter int unsigned PATTERN_POSITIONS = 8,
  parameter int unsigned CONDS_PER_RULE    = 4
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  tfmc_pkg::ctrl_cmd_t                               cmd_i,
  output tfmc_pkg::dp_status_t                              status_o,
  input  logic [tfmc_pkg::OpW-1:0]                          operation_i,
  input  logic [tfmc_pkg::PatW-1:0]                         pattern_i,
  input  logic [tfmc_pkg::LenW-1:0]                         pattern_length_i,
  input  logic [tfmc_pkg::InConds-1:0][tfmc_pkg::IdxW-1:0]  cond_index_i,
  input  logic [tfmc_pkg::InConds-1:0][tfmc_pkg::ValW-1:0]  cond_value_i,
  input  logic [tfmc_pkg::OutW-1:0]                         rule_output_i,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output logic [tfmc_pkg::OutW-1:0]                         class_value_o,
  output logic [tfmc_pkg::MatchW-1:0]                       first_hit_o,
  output logic                                              accepted_o
);
  import tfmc_pkg::*;

  localparam int unsigned NumConds = (CONDS_PER_RULE < InConds) ? CONDS_PER_RULE : InConds;
  localparam int unsigned RuleW    = NumConds * CondW + OutW;
  localparam int unsigned AddrW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CntW     = $clog2(MAX_RULES + 1);

  logic [RuleW-1:0] rule_mem [MAX_RULES];

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]  chk_idx_q, chk_idx_d;
  logic [RuleW-1:0]  rd_data_q;
  logic [PatW-1:0]   pattern_q;
  logic [LenW-1:0]   length_q;
  logic [OutW-1:0]   hold_cls_q, hold_cls_d;
  logic [MatchW-1:0] hold_match_q, hold_match_d;
  logic              hold_acc_q, hold_acc_d;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   res_cls_q;
  logic [MatchW-1:0] res_match_q;
  logic              res_acc_q;

  logic              wr_en;
  logic [RuleW-1:0]  wr_data;
  logic              rd_en;
  logic              rule_hit;
  logic              hit_now;
  logic              table_full;
  logic [2*PatW-1:0] pat_ext;

  assign table_full = (count_q >= CntW'(MAX_RULES));
  assign wr_en      = cmd_i.load && (operation_i == OpAdd) && !table_full;

  always_comb begin
    wr_data = '0;
    for (int c = 0; c < NumConds; c++) begin
      wr_data[c*CondW +: IdxW]      = cond_index_i[c];
      wr_data[c*CondW + IdxW +: ValW] = cond_value_i[c];
    end
    wr_data[NumConds*CondW +: OutW] = rule_output_i;
  end

  assign pat_ext = {{PatW{1'b0}}, pattern_q};

  always_comb begin
    logic             ended;
    logic [IdxW-1:0]  ix;
    logic [ValW-1:0]  want;
    logic [ValW-1:0]  code;
    rule_hit = 1'b1;
    ended    = 1'b0;
    for (int c = 0; c < NumConds; c++) begin
      ix   = rd_data_q[c*CondW +: IdxW];
      want = rd_data_q[c*CondW + IdxW +: ValW];
      code = pat_ext[{ix[IdxW-2:0], 1'b0} +: ValW];
      if (ix[IdxW-1]) begin
        ended = 1'b1;
      end
      if (!ended && (ix[IdxW-2:0] < length_q) &&
          (int'(ix[IdxW-2:0]) < PATTERN_POSITIONS) && (code != want)) begin
        rule_hit = 1'b0;
        ended    = 1'b1;
      end
    end
  end

  assign hit_now            = cmd_i.scan && rd_vld_q && rule_hit;
  assign rd_en              = cmd_i.scan && !hit_now && (rd_ptr_q < count_q);
  assign status_o.scan_done = cmd_i.scan && (hit_now || (!rd_vld_q && (rd_ptr_q >= count_q)));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    rd_vld_d     = rd_vld_q;
    chk_idx_d    = chk_idx_q;
    hold_cls_d   = hold_cls_q;
    hold_match_d = hold_match_q;
    hold_acc_d   = hold_acc_q;
    out_valid_d  = out_valid_q;
    if (cmd_i.load) begin
      rd_ptr_d     = '0;
      rd_vld_d     = 1'b0;
      hold_cls_d   = '0;
      hold_match_d = NoMatch;
      hold_acc_d   = 1'b0;
      case (operation_i)
        OpAdd: begin
          if (!table_full) begin
            count_d    = count_q + CntW'(1);
            hold_acc_d = 1'b1;
          end
        end
        OpClear: begin
          count_d    = '0;
          hold_acc_d = 1'b1;
        end
        default: begin
          hold_acc_d = 1'b0;
        end
      endcase
    end
    if (cmd_i.scan) begin
      rd_vld_d = rd_en;
      if (rd_en) begin
        rd_ptr_d  = rd_ptr_q + CntW'(1);
        chk_idx_d = rd_ptr_q[AddrW-1:0];
      end
      if (hit_now) begin
        hold_cls_d   = rd_data_q[NumConds*CondW +: OutW];
        hold_match_d = MatchW'(chk_idx_q);
      end
    end
    if (cmd_i.deliver) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    hold_cls_q   <= hold_cls_d;
    hold_match_q <= hold_match_d;
    hold_acc_q   <= hold_acc_d;
    if (cmd_i.load) begin
      pattern_q <= pattern_i;
      length_q  <= pattern_length_i;
    end
    if (cmd_i.deliver) begin
      res_cls_q   <= hold_cls_q;
      res_match_q <= hold_match_q;
      res_acc_q   <= hold_acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rule_mem[count_q[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= rule_mem[rd_ptr_q[AddrW-1:0]];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign class_value_o  = res_cls_q;
  assign first_hit_o    = res_match_q;
  assign accepted_o     = res_acc_q;

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RULES))
    else $error("Rule count exceeds the table size.");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && (operation_i == OpClear)) |=> (count_q == '0))
    else $error("Clear did not empty the rule table.");

  a_hit_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_now |-> ({1'b0, chk_idx_q} < {1'b0, count_q}))
    else $error("Matched rule lies beyond the rule count.");

  a_deliver_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deliver |=> out_valid_q)
    else $error("Delivered result is not presented on the output.");

endmodule

### hdl/ternary_rule_first_match_classifier_top.sv
// Top level of the ternary rule first-match classifier.
// Joins tfmc_ctrl and tfmc_dp; depends on tfmc_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o   operation, pattern, length, conditions, output
//   out      output     out_valid_o/out_stall_i class_value, first_hit, accepted
//
// An add, a clear or an unknown operation shows its result once the output register is free.
// A classify scans the stored rules in order and shows the first hit, or no match, once the
// output is free; the rule memory delivers one rule per cycle to the match logic.
// Reset empties the rule table at once; rule memory contents are not cleared.
// One item is in work at a time; one more may be taken while a result waits at the output.
module ternary_rule_first_match_classifier_top #(
  parameter int unsigned MAX_RULES         = 32,
  parameter int unsigned PATTERN_POSITIONS = 8,
  parameter int unsigned CONDS_PER_RULE    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tfmc_pkg::OpW-1:0]            operation_i,
  input  logic [tfmc_pkg::PatW-1:0]           pattern_i,
  input  logic [tfmc_pkg::LenW-1:0]           pattern_length_i,
  input  logic signed [tfmc_pkg::IdxW-1:0]    cond_index_0_i,
  input  logic signed [tfmc_pkg::IdxW-1:0]    cond_index_1_i,
  input  logic signed [tfmc_pkg::IdxW-1:0]    cond_index_2_i,
  input  logic signed [tfmc_pkg::IdxW-1:0]    cond_index_3_i,
  input  logic signed [tfmc_pkg::ValW-1:0]    cond_value_0_i,
  input  logic signed [tfmc_pkg::ValW-1:0]    cond_value_1_i,
  input  logic signed [tfmc_pkg::ValW-1:0]    cond_value_2_i,
  input  logic signed [tfmc_pkg::ValW-1:0]    cond_value_3_i,
  input  logic signed [tfmc_pkg::OutW-1:0]    rule_output_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tfmc_pkg::OutW-1:0]    class_value_o,
  output logic signed [tfmc_pkg::MatchW-1:0]  first_hit_o,
  output logic                                accepted_o
);
  import tfmc_pkg::*;

  ctrl_cmd_t                       cmd;
  dp_status_t                      status;
  logic [InConds-1:0][IdxW-1:0]    cond_index;
  logic [InConds-1:0][ValW-1:0]    cond_value;
  logic [OutW-1:0]                 class_value;
  logic [MatchW-1:0]               first_hit;

  assign cond_index = {cond_index_3_i, cond_index_2_i, cond_index_1_i, cond_index_0_i};
  assign cond_value = {cond_value_3_i, cond_value_2_i, cond_value_1_i, cond_value_0_i};

  tfmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tfmc_dp #(
    .MAX_RULES         (MAX_RULES),
    .PATTERN_POSITIONS (PATTERN_POSITIONS),
    .CONDS_PER_RULE    (CONDS_PER_RULE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (operation_i),
    .pattern_i        (pattern_i),
    .pattern_length_i (pattern_length_i),
    .cond_index_i     (cond_index),
    .cond_value_i     (cond_value),
    .rule_output_i    (rule_output_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .class_value_o    (class_value),
    .first_hit_o      (first_hit),
    .accepted_o       (accepted_o)
  );

  assign class_value_o  = class_value;
  assign first_hit_o    = first_hit;

endmodule

### test/testbench.sv
// Testbench for ternary_rule_first_match_classifier_top: a table of directed rule
// transfers, then random rule sets and classify transfers against a local rule table.
// Depends on tfmc_pkg and the RTL of the classifier.
module testbench;
  import tfmc_pkg::*;

  localparam int MaxRules = 32;
  localparam int PatternPositions = 8;
  localparam int CondsPerRule = 4;
  localparam int ClkPeriod = 8;
  localparam int ResetCycles = 11;
  localparam int TotalItems = 1650;
  localparam int HoldCycles = 64;
  localparam int SettleCycles = MaxRules + 8;
  localparam int LimitCycles = 400_000;

  localparam logic [OpW-1:0] OpUnknown = 2'd3;
  localparam logic [ValW-1:0] VZero = 2'b00;
  localparam logic [ValW-1:0] VPlus = 2'b01;
  localparam logic [ValW-1:0] VMinus = 2'b11;
  localparam logic [ValW-1:0] VOdd = 2'b10;
  localparam logic [IdxW-1:0] IdxEnd = 5'h1F;
  localparam logic [IdxW-1:0] IdxMostNeg = 5'h10;
  localparam bit Typed = 1'b1;
  localparam bit Predicted = 1'b0;

  typedef struct packed {
    logic [OpW-1:0]              op;
    logic [PatW-1:0]             pat;
    logic [LenW-1:0]             len;
    logic [0:InConds-1][IdxW-1:0] idx;
    logic [0:InConds-1][ValW-1:0] val;
    logic [OutW-1:0]             out;
  } cmd_t;

  typedef struct packed {
    logic [OutW-1:0]   cls;
    logic [MatchW-1:0] rule;
    logic              acc;
  } answer_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    answer_t answer;
  } directed_row_t;

  // Columns: operation, pattern, length, indices, values, output, typed, class, rule, accepted.
  localparam int DirectedCount = 20;
  localparam directed_row_t DirectedStim [DirectedCount] = '{
    {OpClassify, 16'hFFFF, 4'd15, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VMinus, VMinus, VMinus, VMinus}, VMinus, Typed, VZero, NoMatch, 1'b0},
    {OpUnknown, 16'hFFFF, 4'd15, {5'd15, 5'd15, 5'd15, 5'd15},
     {VMinus, VMinus, VMinus, VMinus}, VMinus, Typed, VZero, NoMatch, 1'b0},
    {OpClear, 16'h0000, 4'd0, {5'd0, 5'd0, 5'd0, 5'd0},
     {VZero, VZero, VZero, VZero}, VZero, Typed, VZero, NoMatch, 1'b1},
    {OpAdd, 16'h0000, 4'd8, {5'd0, 5'd1, IdxEnd, 5'd2},
     {VPlus, VMinus, VPlus, VPlus}, VPlus, Typed, VZero, NoMatch, 1'b1},
    {OpAdd, 16'hFFFF, 4'd8, {IdxMostNeg, 5'd0, 5'd0, 5'd0},
     {VOdd, VOdd, VOdd, VOdd}, VOdd, Typed, VZero, NoMatch, 1'b1},
    {OpClassify, 16'h000D, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'h0000, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'h000D, 4'd1, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'h0001, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClear, 16'hFFFF, 4'd15, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VMinus, VMinus, VMinus, VMinus}, VMinus, Typed, VZero, NoMatch, 1'b1},
    {OpAdd, 16'h0000, 4'd8, {5'd15, 5'd8, 5'd7, 5'd3},
     {VPlus, VMinus, VOdd, VZero}, VMinus, Typed, VZero, NoMatch, 1'b1},
    {OpAdd, 16'h0000, 4'd8, {5'd2, IdxEnd, 5'd9, 5'd4},
     {VMinus, VPlus, VPlus, VPlus}, VPlus, Typed, VZero, NoMatch, 1'b1},
    {OpClassify, 16'h8000, 4'd15, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'hC000, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'hC030, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'hC000, 4'd7, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'hFFFF, 4'd0, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpClassify, 16'h80C0, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0},
    {OpUnknown, 16'h0000, 4'd0, {5'd0, 5'd0, 5'd0, 5'd0},
     {VZero, VZero, VZero, VZero}, VZero, Typed, VZero, NoMatch, 1'b0},
    {OpClassify, 16'h8000, 4'd8, {IdxEnd, IdxEnd, IdxEnd, IdxEnd},
     {VZero, VZero, VZero, VZero}, VZero, Predicted, VZero, NoMatch, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OpW-1:0] operation_i = '0;
  logic [PatW-1:0] pattern_i = '0;
  logic [LenW-1:0] pattern_length_i = '0;
  logic signed [IdxW-1:0] cond_index_0_i = '0;
  logic signed [IdxW-1:0] cond_index_1_i = '0;
  logic signed [IdxW-1:0] cond_index_2_i = '0;
  logic signed [IdxW-1:0] cond_index_3_i = '0;
  logic signed [ValW-1:0] cond_value_0_i = '0;
  logic signed [ValW-1:0] cond_value_1_i = '0;
  logic signed [ValW-1:0] cond_value_2_i = '0;
  logic signed [ValW-1:0] cond_value_3_i = '0;
  logic signed [OutW-1:0] rule_output_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OutW-1:0] class_value_o;
  logic signed [MatchW-1:0] first_hit_o;
  logic accepted_o;

  cmd_t model_rules [MaxRules];
  int model_count = 0;
  answer_t answers_due [$];
  int mismatches = 0;
  int items_sent = 0;
  bit steady = 1'b0;
  bit hold_outputs = 1'b0;

  ternary_rule_first_match_classifier_top #(
    .MAX_RULES(MaxRules),
    .PATTERN_POSITIONS(PatternPositions),
    .CONDS_PER_RULE(CondsPerRule)
  ) u_dut (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit rule_hits(input cmd_t rl, input logic [PatW-1:0] pat,
                                   input logic [LenW-1:0] len);
    int p;
    for (int i = 0; i < InConds && i < CondsPerRule; i++) begin
      if (rl.idx[i][IdxW-1]) return 1'b1;
      p = rl.idx[i];
      if (p < len && p < PatternPositions && pat[2*p +: 2] != rl.val[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic answer_t rule_table_answer(input cmd_t c);
    answer_t a;
    a = '{cls: VZero, rule: NoMatch, acc: 1'b0};
    case (c.op)
      OpAdd: begin
        if (model_count < MaxRules) begin
          model_rules[model_count] = c;
          model_count++;
          a.acc = 1'b1;
        end
      end
      OpClassify: begin
        for (int k = 0; k < model_count; k++) begin
          if (rule_hits(model_rules[k], c.pat, c.len)) begin
            a.cls = model_rules[k].out;
            a.rule = MatchW'(k);
            break;
          end
        end
      end
      OpClear: begin
        model_count = 0;
        a.acc = 1'b1;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [ValW-1:0] ternary_code();
    case ($urandom_range(0, 2))
      0: return VZero;
      1: return VPlus;
      default: return VMinus;
    endcase
  endfunction

  function automatic cmd_t random_cmd(input logic [OpW-1:0] op);
    logic [63:0] r;
    cmd_t c;
    r = {$urandom, $urandom};
    c = r[$bits(cmd_t)-1:0];
    c.op = op;
    return c;
  endfunction

  function automatic cmd_t random_rule();
    cmd_t c;
    int n;
    c = random_cmd(OpAdd);
    n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < InConds; i++) begin
      if (i < n) begin
        c.idx[i] = ($urandom_range(0, 5) == 0) ? IdxW'($urandom_range(8, 15))
                                               : IdxW'($urandom_range(0, 7));
        c.val[i] = ($urandom_range(0, 15) == 0) ? VOdd : ternary_code();
      end else if (i == n) begin
        c.idx[i] = IdxMostNeg | IdxW'($urandom_range(0, 15));
      end
    end
    return c;
  endfunction

  // Most patterns are built to satisfy one stored rule so that scans end deep in the table.
  function automatic cmd_t classify_item();
    cmd_t c;
    cmd_t rl;
    int p;
    c = random_cmd(OpClassify);
    if ($urandom_range(0, 3) != 0) c.len = 4'd8;
    for (int i = 0; i < PatternPositions; i++) begin
      c.pat[2*i +: 2] = ($urandom_range(0, 15) == 0) ? VOdd : ternary_code();
    end
    if (model_count > 0 && $urandom_range(0, 2) != 0) begin
      rl = model_rules[$urandom_range(0, model_count - 1)];
      for (int i = 0; i < InConds; i++) begin
        if (rl.idx[i][IdxW-1]) break;
        p = rl.idx[i];
        if (p < PatternPositions) c.pat[2*p +: 2] = rl.val[i];
      end
    end
    return c;
  endfunction

  task automatic send(input cmd_t c, input bit typed = 1'b0, input answer_t typed_answer = '0);
    int gap;
    answer_t a;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= c.op;
    pattern_i <= c.pat;
    pattern_length_i <= c.len;
    cond_index_0_i <= c.idx[0];
    cond_index_1_i <= c.idx[1];
    cond_index_2_i <= c.idx[2];
    cond_index_3_i <= c.idx[3];
    cond_value_0_i <= c.val[0];
    cond_value_1_i <= c.val[1];
    cond_value_2_i <= c.val[2];
    cond_value_3_i <= c.val[3];
    rule_output_i <= c.out;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    a = rule_table_answer(c);
    answers_due.push_back(typed ? typed_answer : a);
    if (c.op != OpUnknown) items_sent++;
  endtask

  task automatic wait_for_answers();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answers_due.size() != 0);
  endtask

  task automatic send_maybe_noise();
    if ($urandom_range(0, 19) == 0) send(random_cmd(OpW'($urandom_range(0, 3))));
  endtask

  task automatic report_mismatch(input string what, input logic signed [7:0] got,
                                 input logic signed [7:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding", $signed(first_hit_o),
                        $signed(NoMatch));
      end else begin
        want = answers_due.pop_front();
        if (class_value_o !== $signed(want.cls))
          report_mismatch("class_value", $signed(class_value_o), $signed(want.cls));
        if (first_hit_o !== $signed(want.rule))
          report_mismatch("first_hit", $signed(first_hit_o), $signed(want.rule));
        if (accepted_o !== want.acc)
          report_mismatch("accepted", $signed({1'b0, accepted_o}), $signed({1'b0, want.acc}));
      end
    end
  end

  initial begin : result_receiver
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        wait_cycles = HoldCycles;
      end else begin
        wait_cycles = draw_gap();
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin : stimulus
    int round;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCount; i++) begin
      send(DirectedStim[i].cmd, DirectedStim[i].typed, DirectedStim[i].answer);
    end
    wait_for_answers();

    round = 0;
    while (items_sent < TotalItems) begin
      steady = ($urandom_range(0, 3) == 0);
      if (round == 2 || round == 12) hold_outputs = 1'b1;
      if ($urandom_range(0, 1) != 0) send(random_cmd(OpClear));
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8))
      begin
        send_maybe_noise();
        send(random_rule());
      end
      repeat ($urandom_range(4, 20)) begin
        send_maybe_noise();
        send(classify_item());
      end
      if ($urandom_range(0, 7) == 0) wait_for_answers();
      round++;
    end

    wait_for_answers();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### ternary_rule_first_match_classifier_top.f
hdl/tfmc_pkg.sv
hdl/tfmc_ctrl.sv
hdl/tfmc_dp.sv
hdl/ternary_rule_first_match_classifier_top.sv
test/testbench.sv
